// ----- design/ias_pkg.sv -----
// ----------------------------------------------------------------------------
// ias_pkg
// shared constants and types of the instruction executor
// ----------------------------------------------------------------------------
package ias_pkg;
   localparam int MEM_WORDS = 1024;
   localparam int MEM_AW    = $clog2(MEM_WORDS);
   localparam int PC_W      = 11;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;
   localparam logic [1:0] OP_STEP  = 2'd3;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_HALTED  = 3'd1;
   localparam logic [2:0] ST_END     = 3'd2;
   localparam logic [2:0] ST_DIVZERO = 3'd3;
   localparam logic [2:0] ST_BADADDR = 3'd4;
   localparam logic [2:0] ST_STOPPED = 3'd5;

   localparam logic [7:0] OPC_HALT  = 8'h00;
   localparam logic [7:0] OPC_LOAD  = 8'h01;
   localparam logic [7:0] OPC_LNEG  = 8'h02;
   localparam logic [7:0] OPC_LABS  = 8'h03;
   localparam logic [7:0] OPC_LNABS = 8'h04;
   localparam logic [7:0] OPC_ADD   = 8'h05;
   localparam logic [7:0] OPC_SUB   = 8'h06;
   localparam logic [7:0] OPC_ADDA  = 8'h07;
   localparam logic [7:0] OPC_SUBA  = 8'h08;
   localparam logic [7:0] OPC_LDMQ  = 8'h09;
   localparam logic [7:0] OPC_MQAC  = 8'h0A;
   localparam logic [7:0] OPC_MUL   = 8'h0B;
   localparam logic [7:0] OPC_DIV   = 8'h0C;
   localparam logic [7:0] OPC_JL    = 8'h0D;
   localparam logic [7:0] OPC_JR    = 8'h0E;
   localparam logic [7:0] OPC_JPL   = 8'h0F;
   localparam logic [7:0] OPC_JPR   = 8'h10;
   localparam logic [7:0] OPC_STOR  = 8'h11;
   localparam logic [7:0] OPC_STL   = 8'h12;
   localparam logic [7:0] OPC_STR   = 8'h13;
   localparam logic [7:0] OPC_LSH   = 8'h14;
   localparam logic [7:0] OPC_RSH   = 8'h15;

   typedef struct packed {
      logic          we;
      logic [MEM_AW-1:0] addr;
      logic [39:0]   wdata;
   } mem_req_type;

   function automatic logic [39:0] abs40(input logic [39:0] x);
      return x[39] ? 40'(-x) : x;
   endfunction
endpackage

// ----- design/ias_instruction_executor.sv -----
// ----------------------------------------------------------------------------
// ias_instruction_executor
// 40-bit two-instruction-per-word machine with its own word memory
// ----------------------------------------------------------------------------
// writes, starts and refused steps go to the response, reads wait on memory,
// steps fetch, decode and execute; mul/div go one bit a cycle in the shared unit
// one word at a time: busy stays high until the response strobe
// the receiver cannot stall; rsp_valid is high for one cycle per word
// synchronous reset clears control state, AC, MQ, PC and run state; memory is not cleared
module ias_instruction_executor (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_op,
   input  logic [9:0]   req_address,
   input  logic [39:0]  req_data,
   output logic         rsp_valid,
   output logic [2:0]   rsp_status,
   output logic [39:0]  rsp_read_data,
   output logic [7:0]   rsp_opcode,
   output logic [11:0]  rsp_operand_address,
   output logic [39:0]  rsp_acc,
   output logic [39:0]  rsp_mq,
   output logic [10:0]  rsp_pc,
   output logic         rsp_right_half_next,
   output logic         rsp_is_running
);
   import ias_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_FETCH  = 4'd1;
   localparam logic [3:0] S_DEC    = 4'd2;
   localparam logic [3:0] S_OPRD   = 4'd3;
   localparam logic [3:0] S_EXEC   = 4'd4;
   localparam logic [3:0] S_MD     = 4'd5;
   localparam logic [3:0] S_MDFIN  = 4'd6;
   localparam logic [3:0] S_RESP   = 4'd7;
   localparam logic [3:0] S_RDWAIT = 4'd8;

   logic [3:0]  state_ff, state_in;
   logic [9:0]  addr_ff, addr_in;
   logic [39:0] ac_ff, ac_in;
   logic [39:0] mq_ff, mq_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic [19:0] rbuf_ff, rbuf_in;
   logic        rpend_ff, rpend_in;
   logic        run_ff, run_in;
   logic [19:0] ins_ff, ins_in;
   logic        right_ff, right_in;
   logic        neg_a_ff, neg_a_in, neg_b_ff, neg_b_in;
   logic [2:0]  st_ff, st_in;
   logic [39:0] rd_ff, rd_in;
   logic [7:0]  ropc_ff, ropc_in;
   logic [11:0] roa_ff, roa_in;
   logic        rv_ff, rv_in;

   mem_req_type mreq;
   logic [39:0] mrd;
   logic        md_go, md_div, md_done;
   logic [39:0] md_a, md_b, md_hi, md_lo;

   ias_word_memory u_mem (.clock(clock), .req(mreq), .rdata(mrd));
   ias_muldiv u_md (
      .clock(clock), .reset(reset), .go(md_go), .is_div(md_div),
      .a(md_a), .b(md_b), .done(md_done), .hi(md_hi), .lo(md_lo)
   );

   logic [7:0]  code;
   logic [11:0] oa;
   logic        uses;
   logic [39:0] m, am;
   logic [39:0] qv, rv;
   logic [79:0] prod;
   always_comb begin
      code = ins_ff[19:12];
      oa   = ins_ff[11:0];
      uses = ((code >= OPC_LOAD) && (code <= OPC_LDMQ)) ||
             ((code >= OPC_MUL) && (code <= OPC_STR));
      m    = mrd;
      am   = abs40(mrd);
      prod = neg_a_ff ^ neg_b_ff ? 80'(-{md_hi, md_lo}) : {md_hi, md_lo};
      qv   = (neg_a_ff ^ neg_b_ff) ? 40'(-md_lo) : md_lo;
      rv   = neg_a_ff ? 40'(-md_hi) : md_hi;
   end

   always_comb begin
      state_in = state_ff; addr_in = addr_ff;
      ac_in = ac_ff; mq_in = mq_ff; pc_in = pc_ff; rbuf_in = rbuf_ff;
      rpend_in = rpend_ff; run_in = run_ff; ins_in = ins_ff; right_in = right_ff;
      neg_a_in = neg_a_ff; neg_b_in = neg_b_ff; st_in = st_ff; rd_in = rd_ff;
      ropc_in = ropc_ff; roa_in = roa_ff; rv_in = 1'b0;
      mreq = '{we: 1'b0, addr: addr_ff[MEM_AW-1:0], wdata: ac_ff};
      md_go = 1'b0; md_div = 1'b0; md_a = '0; md_b = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               addr_in = req_address;
               st_in = ST_OK; rd_in = '0; ropc_in = '0; roa_in = '0;
               mreq.addr = req_address[MEM_AW-1:0];
               case (req_op)
                  OP_WRITE: begin
                     mreq.we = 1'b1; mreq.wdata = req_data;
                     state_in = S_RESP;
                  end
                  OP_READ: state_in = S_RDWAIT;
                  OP_START: begin
                     ac_in = '0; mq_in = '0; pc_in = {1'b0, req_address};
                     rpend_in = 1'b0; run_in = 1'b1; state_in = S_RESP;
                  end
                  default: begin
                     if (!run_ff) begin
                        st_in = ST_STOPPED; state_in = S_RESP;
                     end else if (rpend_ff) begin
                        ins_in = rbuf_ff; right_in = 1'b1; rpend_in = 1'b0;
                        state_in = S_DEC;
                     end else if (pc_ff >= PC_W'(MEM_WORDS)) begin
                        st_in = ST_END; run_in = 1'b0; rpend_in = 1'b0;
                        state_in = S_RESP;
                     end else begin
                        mreq.addr = pc_ff[MEM_AW-1:0];
                        right_in = 1'b0; state_in = S_FETCH;
                     end
                  end
               endcase
            end
         end
         S_RDWAIT: begin
            rd_in = mrd; state_in = S_RESP;
         end
         S_FETCH: begin
            ins_in = mrd[39:20]; rbuf_in = mrd[19:0]; rpend_in = 1'b1;
            state_in = S_DEC;
         end
         S_DEC: begin
            ropc_in = code; roa_in = oa;
            mreq.addr = oa[MEM_AW-1:0];
            if (uses && oa >= 12'(MEM_WORDS)) begin
               st_in = ST_BADADDR; run_in = 1'b0; rpend_in = 1'b0;
               state_in = S_RESP;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
            mreq.addr = oa[MEM_AW-1:0];
            case (code)
               OPC_HALT: begin
                  st_in = ST_HALTED; run_in = 1'b0; rpend_in = 1'b0;
               end
               OPC_LOAD:  ac_in = m;
               OPC_LNEG:  ac_in = 40'(-m);
               OPC_LABS:  ac_in = am;
               OPC_LNABS: ac_in = 40'(-am);
               OPC_ADD:   ac_in = ac_ff + m;
               OPC_SUB:   ac_in = ac_ff - m;
               OPC_ADDA:  ac_in = ac_ff + am;
               OPC_SUBA:  ac_in = ac_ff - am;
               OPC_LDMQ:  mq_in = m;
               OPC_MQAC:  ac_in = mq_ff;
               OPC_MUL: begin
                  md_go = 1'b1; md_a = abs40(mq_ff); md_b = am;
                  neg_a_in = mq_ff[39]; neg_b_in = m[39]; state_in = S_MD;
               end
               OPC_DIV: begin
                  if (m == '0) begin
                     st_in = ST_DIVZERO; run_in = 1'b0; rpend_in = 1'b0;
                  end else begin
                     md_go = 1'b1; md_div = 1'b1; md_a = abs40(ac_ff); md_b = am;
                     neg_a_in = ac_ff[39]; neg_b_in = m[39]; state_in = S_MD;
                  end
               end
               OPC_JL: begin
                  pc_in = PC_W'(oa); rpend_in = 1'b0;
               end
               OPC_JR: begin
                  pc_in = PC_W'(oa); rbuf_in = m[19:0]; rpend_in = 1'b1;
               end
               OPC_JPL: begin
                  if (!ac_ff[39]) begin
                     pc_in = PC_W'(oa); rpend_in = 1'b0;
                  end
               end
               OPC_JPR: begin
                  if (!ac_ff[39]) begin
                     pc_in = PC_W'(oa); rbuf_in = m[19:0]; rpend_in = 1'b1;
                  end
               end
               OPC_STOR: begin
                  mreq.we = 1'b1; mreq.wdata = ac_ff;
               end
               OPC_STL: begin
                  mreq.we = 1'b1; mreq.wdata = {m[39:32], ac_ff[11:0], m[19:0]};
               end
               OPC_STR: begin
                  mreq.we = 1'b1; mreq.wdata = {m[39:12], ac_ff[11:0]};
               end
               OPC_LSH: ac_in = {ac_ff[38:0], 1'b0};
               OPC_RSH: ac_in = {ac_ff[39], ac_ff[39:1]};
               default: ;
            endcase
            if (right_ff && code != OPC_HALT && !(code == OPC_DIV && m == '0)) begin
               if (!(code == OPC_JL || code == OPC_JR ||
                     ((code == OPC_JPL || code == OPC_JPR) && !ac_ff[39]))) begin
                  pc_in = pc_ff + PC_W'(1);
               end
            end
         end
         S_MD: begin
            if (md_done) begin
               state_in = S_MDFIN;
            end
         end
         S_MDFIN: begin
            if (code == OPC_DIV) begin
               mq_in = qv; ac_in = rv;
            end else begin
               ac_in = prod[79:40]; mq_in = prod[39:0];
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            rv_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; ac_ff <= '0; mq_ff <= '0; pc_ff <= '0;
         rbuf_ff <= '0; rpend_ff <= 1'b0; run_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ac_ff <= ac_in; mq_ff <= mq_in; pc_ff <= pc_in;
         rbuf_ff <= rbuf_in; rpend_ff <= rpend_in; run_ff <= run_in;
         rv_ff <= rv_in;
      end
      addr_ff <= addr_in; ins_ff <= ins_in;
      right_ff <= right_in; neg_a_ff <= neg_a_in; neg_b_ff <= neg_b_in;
      st_ff <= st_in; rd_ff <= rd_in; ropc_ff <= ropc_in; roa_ff <= roa_in;
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = rv_ff;
   assign rsp_status          = st_ff;
   assign rsp_read_data       = rd_ff;
   assign rsp_opcode          = ropc_ff;
   assign rsp_operand_address = roa_ff;
   assign rsp_acc             = ac_ff;
   assign rsp_mq              = mq_ff;
   assign rsp_pc              = pc_ff;
   assign rsp_right_half_next = rpend_ff;
   assign rsp_is_running      = run_ff;

   a_resp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while busy");
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double response");
   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_running |-> !rsp_right_half_next)
      else $error("pending right half while stopped");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accept not taken");
endmodule

// ----- design/ias_word_memory.sv -----
// ----------------------------------------------------------------------------
// ias_word_memory
// single port word memory, registered read
// ----------------------------------------------------------------------------
module ias_word_memory (
   input  logic                 clock,
   input  ias_pkg::mem_req_type req,
   output logic [39:0]          rdata
);
   import ias_pkg::*;
   logic [39:0] mem [MEM_WORDS];

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.addr] <= req.wdata;
      end
      rdata <= mem[req.addr];
   end
endmodule

// ----- design/ias_muldiv.sv -----
// ----------------------------------------------------------------------------
// ias_muldiv
// iterative unsigned multiply (shift add) and restoring divide, one bit a cycle
// ----------------------------------------------------------------------------
module ias_muldiv (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic        is_div,
   input  logic [39:0] a,
   input  logic [39:0] b,
   output logic        done,
   output logic [39:0] hi,
   output logic [39:0] lo
);
   import ias_pkg::*;
   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        div_ff, div_in;
   logic [40:0] hi_ff, hi_in;
   logic [39:0] lo_ff, lo_in;
   logic [39:0] b_ff, b_in;
   logic [40:0] sum;
   logic [40:0] rem_sh;
   logic [40:0] diff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      b_in    = b_ff;
      sum     = hi_ff + (lo_ff[0] ? {1'b0, b_ff} : 41'd0);
      rem_sh  = {hi_ff[39:0], lo_ff[39]};
      diff    = rem_sh - {1'b0, b_ff};
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = 6'd40;
         div_in  = is_div;
         hi_in   = '0;
         lo_in   = a;
         b_in    = b;
      end else if (busy_ff) begin
         if (div_ff) begin
            if (!diff[40]) begin
               hi_in = diff;
               lo_in = {lo_ff[38:0], 1'b1};
            end else begin
               hi_in = rem_sh;
               lo_in = {lo_ff[38:0], 1'b0};
            end
         end else begin
            hi_in = {1'b0, sum[40:1]};
            lo_in = {sum[0], lo_ff[39:1]};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      div_ff <= div_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      b_ff   <= b_in;
   end

   logic fin_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff <= 1'b0;
      end else begin
         fin_ff <= busy_ff && cnt_ff == 6'd1;
      end
   end

   assign hi = hi_ff[39:0];
   assign lo = lo_ff;
   always_comb begin
      done = fin_ff;
   end
endmodule
